// ===== sv/sds_pkg.sv =====
// Shared types and constants for the SMTP body dot-stuffer.
// No dependencies.
package sds_pkg;

    localparam int unsigned JOB_BYTES = 5;
    localparam int unsigned JOB_CNT_W = 3;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = 2;
    localparam int unsigned Q_CNT_W   = 3;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_DOT = 8'h2E;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic [JOB_CNT_W-1:0]           count;
        logic [JOB_BYTES-1:0][7:0]      bytes;
    } job_t;

endpackage

// ===== sv/smtp_body_dot_stuffer.sv =====
// SMTP body dot-stuffer: line-end normalization, dot doubling, end marker.
// Top level; instantiates sds_front, sds_fifo and sds_back; depends on sds_pkg.
//
// Usage:
//   Input queue: drive cmd/data_byte with push; a transaction completes when
//   push is high and full is low. cmd=0 is a body byte, cmd=1 ends the message.
//   Output queue: while empty is low, out_byte/out_last show the oldest byte;
//   pop high with empty low takes it. out_last marks the final byte of the
//   bytes produced by one input transaction. A held CR yields no output yet.
//   Config: cfg_we/cfg_wdata write add_delimiter (reset 1); write only idle.
//   Throughput: one output byte per cycle from the back end serializer when
//   pop frees the output register; an input producing k bytes holds it until
//   all k are sent, so plain bytes stream at one per cycle. A 4-entry job
//   queue absorbs expansions; full rises when it fills. When pop is held low
//   the output register and queue hold, then full asserts. Reset clears all
//   line state, queue and output.
module smtp_body_dot_stuffer
    import sds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    job_t fe_job, q_job;
    logic fe_push, q_pop, q_full, q_empty;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    sds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .cmd       (cmd),
        .data_byte (data_byte),
        .job_push  (fe_push),
        .job       (fe_job)
    );

    sds_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_job  (fe_job),
        .rd_en   (q_pop),
        .rd_job  (q_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    sds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule

// ===== sv/sds_front.sv =====
// Front end: accepts body transactions, tracks line state and builds output jobs.
// Depends on sds_pkg.
module sds_front
    import sds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       accept,
    input  logic       cmd,
    input  logic [7:0] data_byte,
    output logic       job_push,
    output job_t       job
);

    logic add_delim_reg, add_delim_next;
    logic held_cr_reg, held_cr_next;
    logic after_nl_reg, after_nl_next;
    logic any_seen_reg, any_seen_next;
    logic [JOB_CNT_W-1:0] n;
    logic first;

    always_comb
    begin
        job  = '0;
        n    = '0;
        first = !any_seen_reg;
        held_cr_next  = held_cr_reg;
        after_nl_next = after_nl_reg;
        any_seen_next = any_seen_reg;
        add_delim_next = cfg_we ? cfg_wdata : add_delim_reg;
        if (cmd == CMD_END)
        begin
            if (any_seen_reg && !after_nl_reg)
            begin
                job.bytes[n] = BYTE_CR; n = n + 1'b1;
                job.bytes[n] = BYTE_LF; n = n + 1'b1;
            end
            job.bytes[n] = BYTE_DOT; n = n + 1'b1;
            job.bytes[n] = BYTE_CR;  n = n + 1'b1;
            job.bytes[n] = BYTE_LF;  n = n + 1'b1;
            held_cr_next  = 1'b0;
            after_nl_next = 1'b0;
            any_seen_next = 1'b0;
        end
        else
        begin
            if (first && add_delim_reg)
            begin
                job.bytes[n] = BYTE_CR; n = n + 1'b1;
                job.bytes[n] = BYTE_LF; n = n + 1'b1;
            end
            if (held_cr_reg && data_byte != BYTE_LF)
            begin
                job.bytes[n] = BYTE_CR; n = n + 1'b1;
            end
            held_cr_next = 1'b0;
            if (data_byte == BYTE_LF)
            begin
                job.bytes[n] = BYTE_CR; n = n + 1'b1;
                job.bytes[n] = BYTE_LF; n = n + 1'b1;
                after_nl_next = 1'b1;
            end
            else if (data_byte == BYTE_CR)
            begin
                held_cr_next  = 1'b1;
                after_nl_next = 1'b0;
            end
            else
            begin
                if (data_byte == BYTE_DOT && (after_nl_reg || first))
                begin
                    job.bytes[n] = BYTE_DOT; n = n + 1'b1;
                end
                job.bytes[n] = data_byte; n = n + 1'b1;
                after_nl_next = 1'b0;
            end
            any_seen_next = 1'b1;
        end
        job.count = n;
    end

    assign job_push = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_delim_reg <= 1'b1;
            held_cr_reg   <= 1'b0;
            after_nl_reg  <= 1'b0;
            any_seen_reg  <= 1'b0;
        end
        else
        begin
            add_delim_reg <= add_delim_next;
            if (accept)
            begin
                held_cr_reg  <= held_cr_next;
                after_nl_reg <= after_nl_next;
                any_seen_reg <= any_seen_next;
            end
        end
    end

endmodule

// ===== sv/sds_fifo.sv =====
// Short job queue between front and back ends.
// Depends on sds_pkg.
module sds_fifo
    import sds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_full,
    output logic q_empty
);

    job_t mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/sds_back.sv =====
// Back end: serializes queued jobs into output bytes behind an output register.
// Depends on sds_pkg.
module sds_back
    import sds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       out_last
);

    job_t                 cur_job_reg, cur_job_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [JOB_CNT_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_free, emit, is_last, cur_take;

    assign out_free = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && out_free;
    assign is_last  = (idx_reg == cur_job_reg.count - 1'b1);
    assign cur_take = !cur_valid_reg || (emit && is_last);
    assign q_pop    = cur_take && !q_empty;

    always_comb
    begin
        cur_job_next   = cur_job_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (cur_take)
        begin
            cur_valid_next = !q_empty;
            cur_job_next   = q_job;
            idx_next       = '0;
        end
        else if (emit)
            idx_next = idx_reg + 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_job_reg.bytes[idx_reg];
            out_last_next  = is_last;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg  <= cur_job_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_job_reg.count != '0 && idx_reg < cur_job_reg.count))
        else $error("active job has no byte at current index");

    a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !is_last) |=> (cur_valid_reg && idx_reg == $past(idx_reg) + 1'b1))
        else $error("job dropped before its last byte");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && !emit) |=> ($stable(idx_reg) && cur_valid_reg))
        else $error("stalled job changed");

endmodule

// ===== dv/tb_smtp_body_dot_stuffer.sv =====
// Testbench for smtp_body_dot_stuffer: a directed table, then random messages.
// Each output transaction is checked against the row's expected bytes or, where a row gives none, an encoder model.
// Depends on sds_pkg and the smtp_body_dot_stuffer RTL.
module tb_smtp_body_dot_stuffer;
    import sds_pkg::*;

    typedef logic [0:4][7:0] seq_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } enc_t;

    typedef struct {
        logic       cfg_wr;
        logic       cfg_val;
        logic       cmd;
        logic [7:0] data;
        int         n;
        seq_t       seq;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       push = 1'b0;
    logic       cmd = CMD_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       out_last;

    enc_t enc_q[$];
    int   errors = 0;
    bit   quiet = 1'b0;
    int   pop_hold = 0;

    logic mdl_add_delim = 1'b1;
    logic mdl_held_cr = 1'b0;
    logic mdl_after_lf = 1'b0;
    logic mdl_in_body = 1'b0;

    smtp_body_dot_stuffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .data_byte (data_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Encoded bytes for one input transaction; updates the line state.
    task automatic encode_item(input logic c, input logic [7:0] b,
                               output int n, output seq_t s);
        logic first;
        n = 0;
        s = '0;
        if (c == CMD_END)
        begin
            if (mdl_in_body && !mdl_after_lf)
            begin
                s[n] = BYTE_CR; n++;
                s[n] = BYTE_LF; n++;
            end
            s[n] = BYTE_DOT; n++;
            s[n] = BYTE_CR;  n++;
            s[n] = BYTE_LF;  n++;
            mdl_held_cr = 1'b0;
            mdl_after_lf = 1'b0;
            mdl_in_body = 1'b0;
        end
        else
        begin
            first = !mdl_in_body;
            if (first && mdl_add_delim)
            begin
                s[n] = BYTE_CR; n++;
                s[n] = BYTE_LF; n++;
            end
            if (mdl_held_cr && b != BYTE_LF)
            begin
                s[n] = BYTE_CR; n++;
            end
            mdl_held_cr = 1'b0;
            if (b == BYTE_LF)
            begin
                s[n] = BYTE_CR; n++;
                s[n] = BYTE_LF; n++;
                mdl_after_lf = 1'b1;
            end
            else if (b == BYTE_CR)
            begin
                mdl_held_cr = 1'b1;
                mdl_after_lf = 1'b0;
            end
            else
            begin
                if (b == BYTE_DOT && (mdl_after_lf || first))
                begin
                    s[n] = BYTE_DOT; n++;
                end
                s[n] = b; n++;
                mdl_after_lf = 1'b0;
            end
            mdl_in_body = 1'b1;
        end
    endtask

    task automatic send(input logic c, input logic [7:0] b,
                        input int n_typed, input seq_t s_typed);
        int   n;
        seq_t s;
        enc_t e;
        @(negedge clk);
        push <= 1'b1;
        cmd <= c;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        encode_item(c, b, n, s);
        if (n_typed >= 0)
        begin
            n = n_typed;
            s = s_typed;
        end
        for (int k = 0; k < n; k++)
        begin
            e.b = s[k];
            e.last = (k == n - 1);
            enc_q.push_back(e);
        end
    endtask

    task automatic sender_gap();
        int g;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            g = $urandom_range(1, 17);
            @(negedge clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // Written only with nothing in flight; a held CR may still be pending in the line state.
    task automatic set_cfg(input logic v);
        @(negedge clk);
        push <= 1'b0;
        while (enc_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        mdl_add_delim = v;
    endtask

    function automatic row_t mk(logic w, logic v, logic c, logic [7:0] d,
                                int n, seq_t s);
        row_t r;
        r.cfg_wr = w;
        r.cfg_val = v;
        r.cmd = c;
        r.data = d;
        r.n = n;
        r.seq = s;
        return r;
    endfunction

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 9))
            0, 1:    return BYTE_LF;
            2:       return BYTE_CR;
            3, 4:    return BYTE_DOT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 16);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin : check_out
        enc_t e;
        if (rst_n && pop && !empty)
        begin
            if (enc_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction out_byte=%h out_last=%b",
                         $time, out_byte, out_last);
            end
            else
            begin
                e = enc_q.pop_front();
                if (out_byte !== e.b)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, e.b, out_byte);
                end
                if (out_last !== e.last)
                begin
                    errors++;
                    $display("%0t: out_last expected %b actual %b",
                             $time, e.last, out_last);
                end
            end
        end
    end

    initial
    begin
        row_t tab[$];
        int   sent;
        int   msgs;
        int   len;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // n = -1: expectation comes from the encoder model
        tab.push_back(mk(0, 0, CMD_END,  8'h00,    3, {BYTE_DOT, BYTE_CR, BYTE_LF, 16'h0}));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_DOT, 4,
                         {BYTE_CR, BYTE_LF, BYTE_DOT, BYTE_DOT, 8'h0}));
        tab.push_back(mk(0, 0, CMD_DATA, 8'h41,    -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_LF,  -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_DOT, -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_CR,  -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_LF,  -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_CR,  -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_DOT, -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, 8'hFF,    -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, 8'h00,    -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_CR,  -1, '0));
        tab.push_back(mk(0, 0, CMD_END,  8'hFF,    5,
                         {BYTE_CR, BYTE_LF, BYTE_DOT, BYTE_CR, BYTE_LF}));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_LF,  -1, '0));
        tab.push_back(mk(0, 0, CMD_END,  8'h00,    3, {BYTE_DOT, BYTE_CR, BYTE_LF, 16'h0}));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_CR,  -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_CR,  -1, '0));
        tab.push_back(mk(0, 0, CMD_END,  8'h00,    5,
                         {BYTE_CR, BYTE_LF, BYTE_DOT, BYTE_CR, BYTE_LF}));
        tab.push_back(mk(1, 0, CMD_DATA, BYTE_DOT, 2, {BYTE_DOT, BYTE_DOT, 24'h0}));
        tab.push_back(mk(0, 0, CMD_DATA, 8'h80,    -1, '0));
        tab.push_back(mk(0, 0, CMD_END,  8'h00,    -1, '0));
        tab.push_back(mk(0, 0, CMD_DATA, BYTE_CR,  0, '0));
        tab.push_back(mk(0, 0, CMD_END,  8'h00,    5,
                         {BYTE_CR, BYTE_LF, BYTE_DOT, BYTE_CR, BYTE_LF}));
        tab.push_back(mk(1, 1, CMD_END,  8'h00,    3, {BYTE_DOT, BYTE_CR, BYTE_LF, 16'h0}));
        tab.push_back(mk(0, 0, CMD_DATA, 8'h7F,    -1, '0));

        foreach (tab[i])
        begin
            if (tab[i].cfg_wr)
                set_cfg(tab[i].cfg_val);
            send(tab[i].cmd, tab[i].data, tab[i].n, tab[i].seq);
            sender_gap();
        end

        sent = 0;
        msgs = 0;
        while (sent < 360)
        begin
            quiet = (sent >= 300);
            if (msgs % 8 == 7)
                set_cfg(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
            begin
                send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), -1, '0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                begin
                    send(CMD_DATA, body_byte(), -1, '0);
                    sender_gap();
                    sent++;
                end
                send(CMD_END, 8'($urandom_range(0, 255)), -1, '0);
                sent++;
            end
            sender_gap();
            msgs++;
        end

        @(negedge clk);
        push <= 1'b0;
        while (enc_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sds_pkg.sv
sv/sds_front.sv
sv/sds_fifo.sv
sv/sds_back.sv
sv/smtp_body_dot_stuffer.sv
dv/tb_smtp_body_dot_stuffer.sv
